// ===== hw/rtl/mahony_orientation_update_defines.svh =====
// Assertion helpers for the orientation update block.
`ifndef MAHONY_ORIENTATION_UPDATE_DEFINES_SVH
`define MAHONY_ORIENTATION_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MOU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MOU_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mou_pkg.sv =====
`timescale 1ns / 1ps
package mou_pkg;

  localparam int MAC_W = 34;
  localparam int ACC_W = 74;

  localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] CFG_PROP_GAIN     = 2'd1;
  localparam logic [1:0] CFG_INT_GAIN      = 2'd2;

  localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd429496730;
  localparam logic [31:0] PROP_GAIN_RST     = 32'd100663296;
  localparam logic [31:0] INT_GAIN_RST      = 32'd838861;

  localparam logic signed [MAC_W-1:0] DEG2RAD_Q32 = 34'sd74961321;
  localparam logic [39:0] MAG_LIMIT = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic clr;
    logic neg;
    logic shl;
  } mac_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] val);
    logic signed [31:0] res;
    if (val > 48'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (val < -48'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/mahony_orientation_update.sv =====
// Mahony IMU attitude filter. Each item is one accelerometer and gyro sample; the
// result is the attitude quaternion after the sample, plus a flag set when all
// accelerometer counts were zero (state kept, result in the cycle after acceptance).
// Otherwise the time until the result varies with the one-bit-per-cycle magnitude
// scaling before renormalization. The time is set mostly by the bit-serial divider
// (seven 32-step quotients for the two normalizations) and the 32-step square root
// unit, used twice; all products go through one shared 34x34 multiply-accumulate
// unit. One item is in work at a time.
`timescale 1ns / 1ps
`include "mahony_orientation_update_defines.svh"
module mahony_orientation_update #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [31:0] gyro_x,
  input  logic signed [31:0] gyro_y,
  input  logic signed [31:0] gyro_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic               accel_rejected
);
  import mou_pkg::*;

  localparam logic signed [31:0] ONE = 32'(64'sd1 <<< QUAT_FRAC_BITS);
  localparam int GV_SH = 2 * QUAT_FRAC_BITS - 31;
  localparam int GZ_SH = 2 * QUAT_FRAC_BITS - 30;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MAC   = 10'b00_0000_0010,
    S_WAIT  = 10'b00_0000_0100,
    S_STORE = 10'b00_0000_1000,
    S_CHECK = 10'b00_0001_0000,
    S_SCALE = 10'b00_0010_0000,
    S_SQRT  = 10'b00_0100_0000,
    S_DIVGO = 10'b00_1000_0000,
    S_DIV   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  typedef enum logic [4:0] {
    G_SUMSQ, G_V0, G_V1, G_V2, G_E0, G_E1, G_E2,
    G_ISP, G_IKI, G_GYR, G_PE, G_H,
    G_D0, G_D1, G_D2, G_D3, G_NRM
  } grp_t;

  state_t state;
  grp_t   grp;
  logic [1:0] idx;
  logic [1:0] ax;

  logic [31:0] sp;
  logic [31:0] kp;
  logic [31:0] ki;

  logic signed [15:0] ain  [3];
  logic signed [31:0] gin  [3];
  logic signed [31:0] att  [4];
  logic signed [31:0] ierr [3];
  logic signed [31:0] an   [3];
  logic signed [33:0] v    [3];
  logic signed [35:0] e    [3];
  logic signed [31:0] h    [3];
  logic signed [40:0] nq   [4];
  logic [40:0]        mg   [4];
  logic [40:0]        mx;
  logic signed [44:0] tmp;
  logic signed [34:0] gr;
  logic signed [44:0] rate;
  logic [31:0]        root;
  logic               rej;

  logic [15:0] aabs [3];
  logic [40:0] mg_n [4];
  logic [40:0] mx01;
  logic [40:0] mx23;
  logic [40:0] mx_n;

  logic signed [33:0] ta [4];
  logic signed [33:0] tb [4];
  logic               tn [4];
  logic               ts [4];
  logic [1:0]         tlast;

  logic signed [44:0] mq_x;
  logic [45:0]        mq_abs;
  logic [39:0]        mq_m;
  logic [31:0]        mq_g;
  logic [43:0]        mq_mag;
  logic signed [44:0] mq_val;

  logic               mac_issue;
  mac_ctl_t           mac_ctl;
  logic signed [ACC_W-1:0] acc;

  logic        sq_start;
  logic [63:0] sq_in;
  logic [31:0] sq_root;
  logic        sq_done;
  logic        dv_start;
  logic [63:0] dv_in;
  logic [31:0] dv_quo;
  logic        dv_done;
  logic [31:0] dv_u;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      aabs[k] = ain[k][15] ? 16'(-17'(ain[k])) : 16'(ain[k]);
    end
    for (int k = 0; k < 4; k++) begin
      mg_n[k] = nq[k][40] ? 41'(-nq[k]) : 41'(nq[k]);
    end
    mx01 = (mg_n[0] > mg_n[1]) ? mg_n[0] : mg_n[1];
    mx23 = (mg_n[2] > mg_n[3]) ? mg_n[2] : mg_n[3];
    mx_n = (mx01 > mx23) ? mx01 : mx23;
  end

  always_comb begin
    case (grp)
      G_ISP, G_PE: mq_x = 45'(e[ax]);
      G_IKI:       mq_x = tmp;
      G_H:         mq_x = rate;
      default:     mq_x = '0;
    endcase
    case (grp)
      G_IKI:   mq_g = ki;
      G_PE:    mq_g = kp;
      default: mq_g = sp;
    endcase
    mq_abs = mq_x[44] ? 46'(-46'(mq_x)) : 46'(mq_x);
    mq_m   = (mq_abs > 46'(MAG_LIMIT)) ? MAG_LIMIT : mq_abs[39:0];
    mq_mag = (grp == G_IKI || grp == G_PE) ? 44'(acc >>> 30) : 44'(acc >>> 32);
    mq_val = mq_x[44] ? -$signed({1'b0, mq_mag}) : $signed({1'b0, mq_mag});
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ta[k] = '0;
      tb[k] = '0;
      tn[k] = 1'b0;
      ts[k] = 1'b0;
    end
    tlast = 2'd0;
    case (grp)
      G_SUMSQ: begin
        for (int k = 0; k < 3; k++) begin
          ta[k] = 34'(ain[k]);
          tb[k] = 34'(ain[k]);
        end
        tlast = 2'd2;
      end
      G_V0: begin
        ta[0] = 34'(att[1]); tb[0] = 34'(att[3]);
        ta[1] = 34'(att[0]); tb[1] = 34'(att[2]); tn[1] = 1'b1;
        tlast = 2'd1;
      end
      G_V1: begin
        ta[0] = 34'(att[0]); tb[0] = 34'(att[1]);
        ta[1] = 34'(att[2]); tb[1] = 34'(att[3]);
        tlast = 2'd1;
      end
      G_V2: begin
        for (int k = 0; k < 4; k++) begin
          ta[k] = 34'(att[k]);
          tb[k] = 34'(att[k]);
        end
        tn[1] = 1'b1;
        tn[2] = 1'b1;
        tlast = 2'd3;
      end
      G_E0: begin
        ta[0] = 34'(an[1]); tb[0] = v[2];
        ta[1] = 34'(an[2]); tb[1] = v[1]; tn[1] = 1'b1;
        tlast = 2'd1;
      end
      G_E1: begin
        ta[0] = 34'(an[2]); tb[0] = v[0];
        ta[1] = 34'(an[0]); tb[1] = v[2]; tn[1] = 1'b1;
        tlast = 2'd1;
      end
      G_E2: begin
        ta[0] = 34'(an[0]); tb[0] = v[1];
        ta[1] = 34'(an[1]); tb[1] = v[0]; tn[1] = 1'b1;
        tlast = 2'd1;
      end
      G_ISP, G_IKI, G_PE, G_H: begin
        ta[0] = $signed({2'b00, mq_m[31:0]});
        tb[0] = $signed({2'b00, mq_g});
        ta[1] = $signed({26'd0, mq_m[39:32]});
        tb[1] = $signed({2'b00, mq_g});
        ts[1] = 1'b1;
        tlast = 2'd1;
      end
      G_GYR: begin
        ta[0] = 34'(gin[ax]);
        tb[0] = DEG2RAD_Q32;
      end
      G_D0: begin
        ta[0] = 34'(att[1]); tb[0] = 34'(h[0]); tn[0] = 1'b1;
        ta[1] = 34'(att[2]); tb[1] = 34'(h[1]); tn[1] = 1'b1;
        ta[2] = 34'(att[3]); tb[2] = 34'(h[2]); tn[2] = 1'b1;
        tlast = 2'd2;
      end
      G_D1: begin
        ta[0] = 34'(att[0]); tb[0] = 34'(h[0]);
        ta[1] = 34'(att[2]); tb[1] = 34'(h[2]);
        ta[2] = 34'(att[3]); tb[2] = 34'(h[1]); tn[2] = 1'b1;
        tlast = 2'd2;
      end
      G_D2: begin
        ta[0] = 34'(att[0]); tb[0] = 34'(h[1]);
        ta[1] = 34'(att[1]); tb[1] = 34'(h[2]); tn[1] = 1'b1;
        ta[2] = 34'(att[3]); tb[2] = 34'(h[0]);
        tlast = 2'd2;
      end
      G_D3: begin
        ta[0] = 34'(att[0]); tb[0] = 34'(h[2]);
        ta[1] = 34'(att[1]); tb[1] = 34'(h[1]);
        ta[2] = 34'(att[2]); tb[2] = 34'(h[0]); tn[2] = 1'b1;
        tlast = 2'd2;
      end
      G_NRM: begin
        for (int k = 0; k < 4; k++) begin
          ta[k] = $signed({4'd0, mg[k][29:0]});
          tb[k] = $signed({4'd0, mg[k][29:0]});
        end
        tlast = 2'd3;
      end
      default: begin
      end
    endcase
  end

  assign mac_issue   = (state == S_MAC);
  assign mac_ctl.clr = (idx == 2'd0);
  assign mac_ctl.neg = tn[idx];
  assign mac_ctl.shl = ts[idx];

  mou_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .issue (mac_issue),
    .op_a  (ta[idx]),
    .op_b  (tb[idx]),
    .ctl   (mac_ctl),
    .acc   (acc)
  );

  assign sq_start = (state == S_STORE) && (grp == G_SUMSQ || grp == G_NRM);
  assign sq_in    = (grp == G_SUMSQ) ? {acc[33:0], 30'd0} : acc[63:0];

  mou_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .root     (sq_root),
    .done     (sq_done)
  );

  assign dv_start = (state == S_DIVGO);
  assign dv_in    = (grp == G_SUMSQ) ? {3'd0, aabs[idx], 45'd0}
                                     : ({34'd0, mg[idx][29:0]} << QUAT_FRAC_BITS);

  mou_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_in),
    .divisor  (root),
    .quotient (dv_quo),
    .done     (dv_done)
  );

  always_comb begin
    if (grp == G_SUMSQ) begin
      dv_u = (dv_quo > 32'h4000_0000) ? 32'h4000_0000 : dv_quo;
    end else begin
      dv_u = (dv_quo > ONE) ? ONE : dv_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      grp   <= G_SUMSQ;
      idx   <= '0;
      ax    <= '0;
      rej   <= 1'b0;
      sp    <= SAMPLE_PERIOD_RST;
      kp    <= PROP_GAIN_RST;
      ki    <= INT_GAIN_RST;
      att[0] <= ONE;
      att[1] <= '0;
      att[2] <= '0;
      att[3] <= '0;
      for (int k = 0; k < 3; k++) begin
        ierr[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_PERIOD: sp <= cfg_data;
          CFG_PROP_GAIN:     kp <= cfg_data;
          CFG_INT_GAIN:      ki <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ain[0] <= accel_x;
            ain[1] <= accel_y;
            ain[2] <= accel_z;
            gin[0] <= gyro_x;
            gin[1] <= gyro_y;
            gin[2] <= gyro_z;
            idx    <= '0;
            grp    <= G_SUMSQ;
            if (accel_x == 16'sd0 && accel_y == 16'sd0 && accel_z == 16'sd0) begin
              rej   <= 1'b1;
              state <= S_DONE;
            end else begin
              rej   <= 1'b0;
              state <= S_MAC;
            end
          end
        end
        S_MAC: begin
          if (idx == tlast) begin
            idx   <= '0;
            state <= S_WAIT;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_WAIT: begin
          state <= S_STORE;
        end
        S_STORE: begin
          case (grp)
            G_SUMSQ: state <= S_SQRT;
            G_V0: begin
              v[0] <= 34'(acc >>> GV_SH); grp <= G_V1; state <= S_MAC;
            end
            G_V1: begin
              v[1] <= 34'(acc >>> GV_SH); grp <= G_V2; state <= S_MAC;
            end
            G_V2: begin
              v[2] <= 34'(acc >>> GZ_SH); grp <= G_E0; state <= S_MAC;
            end
            G_E0: begin e[0] <= 36'(acc >>> 30); grp <= G_E1; state <= S_MAC; end
            G_E1: begin e[1] <= 36'(acc >>> 30); grp <= G_E2; state <= S_MAC; end
            G_E2: begin
              e[2]  <= 36'(acc >>> 30);
              ax    <= '0;
              grp   <= G_ISP;
              state <= S_MAC;
            end
            G_ISP: begin tmp <= mq_val; grp <= G_IKI; state <= S_MAC; end
            G_IKI: begin
              ierr[ax] <= sat32(48'(ierr[ax]) + 48'(mq_val));
              grp      <= G_GYR;
              state    <= S_MAC;
            end
            G_GYR: begin gr <= 35'(acc >>> 24); grp <= G_PE; state <= S_MAC; end
            G_PE: begin
              rate  <= 45'(gr) + mq_val + 45'(ierr[ax]);
              grp   <= G_H;
              state <= S_MAC;
            end
            G_H: begin
              h[ax] <= sat32(48'(mq_val));
              state <= S_MAC;
              if (ax == 2'd2) begin
                grp <= G_D0;
              end else begin
                ax  <= ax + 2'd1;
                grp <= G_ISP;
              end
            end
            G_D0: begin
              nq[0] <= 41'(att[0]) + 41'(acc >>> 25); grp <= G_D1; state <= S_MAC;
            end
            G_D1: begin
              nq[1] <= 41'(att[1]) + 41'(acc >>> 25); grp <= G_D2; state <= S_MAC;
            end
            G_D2: begin
              nq[2] <= 41'(att[2]) + 41'(acc >>> 25); grp <= G_D3; state <= S_MAC;
            end
            G_D3: begin
              nq[3] <= 41'(att[3]) + 41'(acc >>> 25);
              state <= S_CHECK;
            end
            G_NRM: state <= S_SQRT;
            default: state <= S_IDLE;
          endcase
        end
        S_CHECK: begin
          if (mx_n == '0) begin
            state <= S_DONE;
          end else begin
            for (int k = 0; k < 4; k++) begin
              mg[k] <= mg_n[k];
            end
            mx    <= mx_n;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (mx[40:30] != '0) begin
            for (int k = 0; k < 4; k++) begin
              mg[k] <= mg[k] >> 1;
            end
            mx <= mx >> 1;
          end else if (mx[40:29] == '0) begin
            for (int k = 0; k < 4; k++) begin
              mg[k] <= mg[k] << 1;
            end
            mx <= mx << 1;
          end else begin
            grp   <= G_NRM;
            idx   <= '0;
            state <= S_MAC;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            root  <= sq_root;
            idx   <= '0;
            state <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (dv_done) begin
            if (grp == G_SUMSQ) begin
              an[idx] <= ain[idx][15] ? -$signed(dv_u) : $signed(dv_u);
              if (idx == 2'd2) begin
                idx   <= '0;
                grp   <= G_V0;
                state <= S_MAC;
              end else begin
                idx   <= idx + 2'd1;
                state <= S_DIVGO;
              end
            end else begin
              att[idx] <= nq[idx][40] ? -$signed(dv_u) : $signed(dv_u);
              if (idx == 2'd3) begin
                state <= S_DONE;
              end else begin
                idx   <= idx + 2'd1;
                state <= S_DIVGO;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state != S_IDLE);
  assign out_valid      = (state == S_DONE);
  assign quat_w         = att[0];
  assign quat_x         = att[1];
  assign quat_y         = att[2];
  assign quat_z         = att[3];
  assign accel_rejected = rej;

  `MOU_ASSERT_IMP(a_no_accept_pending, out_valid, in_stall, "item taken while result pending")
  `MOU_ASSERT_IMP(a_div_nonzero, state == S_DIV, root != 32'd0, "divide by zero root")
  `MOU_ASSERT_NXT(a_zero_accel_rej, in_valid && !in_stall && accel_x == 16'sd0 && accel_y == 16'sd0 && accel_z == 16'sd0, out_valid && accel_rejected, "zero accel item not rejected")

endmodule

// ===== hw/rtl/mou_mac.sv =====
`timescale 1ns / 1ps
module mou_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 issue,
  input  logic signed [mou_pkg::MAC_W-1:0]     op_a,
  input  logic signed [mou_pkg::MAC_W-1:0]     op_b,
  input  mou_pkg::mac_ctl_t                    ctl,
  output logic signed [mou_pkg::ACC_W-1:0]     acc
);
  import mou_pkg::*;

  logic signed [2*MAC_W-1:0] prod;
  mac_ctl_t                  pctl;
  logic                      pvld;
  logic signed [ACC_W-1:0]   ext;
  logic signed [ACC_W-1:0]   shifted;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   base;

  always_comb begin
    ext     = ACC_W'(prod);
    shifted = pctl.shl ? (ext <<< 32) : ext;
    term    = pctl.neg ? -shifted : shifted;
    base    = pctl.clr ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= 1'b0;
    end else begin
      pvld <= issue;
    end
    prod <= op_a * op_b;
    pctl <= ctl;
    if (pvld) begin
      acc <= base + term;
    end
  end

endmodule

// ===== hw/rtl/mou_sqrt.sv =====
`timescale 1ns / 1ps
module mou_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);
  import mou_pkg::*;

  logic [63:0] rx;
  logic [63:0] rr;
  logic [63:0] pbit;
  logic [4:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign trial = {1'b0, rr} + {1'b0, pbit};
  assign root  = rr[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
    if (start) begin
      rx   <= radicand;
      rr   <= '0;
      pbit <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if ({1'b0, rx} >= trial) begin
        rx <= rx - trial[63:0];
        rr <= (rr >> 1) + pbit;
      end else begin
        rr <= rr >> 1;
      end
      pbit <= pbit >> 2;
    end
  end

endmodule

// ===== hw/rtl/mou_div.sv =====
`timescale 1ns / 1ps
module mou_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);
  import mou_pkg::*;

  logic [31:0] rem;
  logic [31:0] dl;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, dl[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
    if (start) begin
      rem      <= dividend[63:32];
      dl       <= dividend[31:0];
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= 32'(trial - {1'b0, dvs});
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= trial[31:0];
        quotient <= {quotient[30:0], 1'b0};
      end
      dl <= dl << 1;
    end
  end

endmodule

// ===== dv/mahony_orientation_update_checker.sv =====
`timescale 1ns / 1ps
module mahony_orientation_update_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [31:0] gyro_x,
  input  logic signed [31:0] gyro_y,
  input  logic signed [31:0] gyro_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] quat_w,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  input  logic               accel_rejected,
  output int                 fail_count,
  output int                 pending_count
);
  import mou_pkg::*;

  localparam int FRAC = 30;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] q[4];
    logic               rej;
  } attitude_t;

  logic [31:0]        dt_reg, kp_reg, ki_reg;
  logic signed [31:0] att[4];
  logic signed [31:0] ierr[3];
  attitude_t          attitude_q[$];

  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint gain_mul(input longint a, input logic [31:0] g, input int n);
    longint unsigned m, hi, lo, r, gg;
    m = (a < 0) ? longint'(0) - a : a;
    if (m > 64'd1099511627775) m = 64'd1099511627775;
    gg = {32'd0, g};
    hi = m >> 32;
    lo = m & 64'hFFFF_FFFF;
    r = ((hi * gg) << (32 - n)) + ((lo * gg) >> n);
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip32(input longint v);
    return (v < I32_MIN) ? I32_MIN : ((v > I32_MAX) ? I32_MAX : v);
  endfunction

  function automatic attitude_t update_attitude(input longint a[3], input longint gy[3]);
    attitude_t       res;
    longint          an[3], v[3], e[3], h[3], q[4], d[4], nq[4], u, rate, di;
    longint unsigned s, r, m, mg[4], mx;
    res.rej = 1'b0;
    if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
      for (int i = 0; i < 4; i++) res.q[i] = att[i];
      res.rej = 1'b1;
      return res;
    end
    s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    r = root64(s << 30);
    for (int i = 0; i < 3; i++) begin
      m = (a[i] < 0) ? -a[i] : a[i];
      u = longint'((m << 45) / r);
      if (u > ONE) u = ONE;
      an[i] = (a[i] < 0) ? -u : u;
    end
    for (int i = 0; i < 4; i++) q[i] = att[i];
    v[0] = (q[1] * q[3] - q[0] * q[2]) >>> (2 * FRAC - 31);
    v[1] = (q[0] * q[1] + q[2] * q[3]) >>> (2 * FRAC - 31);
    v[2] = (q[0] * q[0] - q[1] * q[1] - q[2] * q[2] + q[3] * q[3]) >>> (2 * FRAC - 30);
    e[0] = (an[1] * v[2] - an[2] * v[1]) >>> 30;
    e[1] = (an[2] * v[0] - an[0] * v[2]) >>> 30;
    e[2] = (an[0] * v[1] - an[1] * v[0]) >>> 30;
    for (int i = 0; i < 3; i++) begin
      di = gain_mul(gain_mul(e[i], dt_reg, 32), ki_reg, 30);
      ierr[i] = 32'(clip32(longint'(ierr[i]) + di));
      rate = ((gy[i] * longint'(DEG2RAD_Q32)) >>> 24) + gain_mul(e[i], kp_reg, 30)
             + longint'(ierr[i]);
      h[i] = clip32(gain_mul(rate, dt_reg, 32));
    end
    d[0] = -(q[1] * h[0] + q[2] * h[1] + q[3] * h[2]);
    d[1] = q[0] * h[0] + q[2] * h[2] - q[3] * h[1];
    d[2] = q[0] * h[1] - q[1] * h[2] + q[3] * h[0];
    d[3] = q[0] * h[2] + q[1] * h[1] - q[2] * h[0];
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      nq[i] = q[i] + (d[i] >>> 25);
      mg[i] = (nq[i] < 0) ? -nq[i] : nq[i];
      if (mg[i] > mx) mx = mg[i];
    end
    if (mx != 0) begin
      while (mx >= (64'd1 << 30)) begin
        mx = mx >> 1;
        for (int i = 0; i < 4; i++) mg[i] = mg[i] >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx = mx << 1;
        for (int i = 0; i < 4; i++) mg[i] = mg[i] << 1;
      end
      s = 0;
      for (int i = 0; i < 4; i++) s = s + mg[i] * mg[i];
      r = root64(s);
      for (int i = 0; i < 4; i++) begin
        u = longint'((mg[i] << FRAC) / r);
        if (u > ONE) u = ONE;
        att[i] = 32'((nq[i] < 0) ? -u : u);
      end
    end
    for (int i = 0; i < 4; i++) res.q[i] = att[i];
    return res;
  endfunction

  function automatic void compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    longint    a[3], g[3];
    attitude_t want;
    if (rst) begin
      dt_reg <= SAMPLE_PERIOD_RST;
      kp_reg <= PROP_GAIN_RST;
      ki_reg <= INT_GAIN_RST;
      att[0] = 32'sd1 <<< FRAC;
      for (int i = 1; i < 4; i++) att[i] = '0;
      for (int i = 0; i < 3; i++) ierr[i] = '0;
      attitude_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_PERIOD: dt_reg <= cfg_data;
          CFG_PROP_GAIN:     kp_reg <= cfg_data;
          CFG_INT_GAIN:      ki_reg <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (attitude_q.size() == 0) begin
          $display("%0t mismatch: unexpected result, expected none actual %0d %0d %0d %0d",
                   $time, quat_w, quat_x, quat_y, quat_z);
          fail_count++;
        end else begin
          want = attitude_q.pop_front();
          compare_field("quat_w", want.q[0], quat_w);
          compare_field("quat_x", want.q[1], quat_x);
          compare_field("quat_y", want.q[2], quat_y);
          compare_field("quat_z", want.q[3], quat_z);
          compare_field("accel_rejected", want.rej, accel_rejected);
        end
      end
      if (in_valid && !in_stall) begin
        a[0] = accel_x; a[1] = accel_y; a[2] = accel_z;
        g[0] = gyro_x;  g[1] = gyro_y;  g[2] = gyro_z;
        attitude_q.push_back(update_attitude(a, g));
      end
    end
    pending_count <= attitude_q.size();
  end

  final begin
    if (attitude_q.size() != 0)
      $display("%0t mismatch: %0d results never arrived", $time, attitude_q.size());
  end

endmodule

// ===== dv/mahony_orientation_update_tb.sv =====
`timescale 1ns / 1ps
module mahony_orientation_update_tb;
  import mou_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_SAMPLE_PERIOD;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [31:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
  logic               accel_rejected;
  int                 fail_count, pending_count;
  int                 tx_idle_pct = 15, rx_idle_pct = 65;
  logic               hold_req = 1'b0;
  int                 hold_left = 0;
  int                 quiet_cycles = 0;
  logic               leftover;

  always #10 clk = ~clk;

  mahony_orientation_update u_top (.*);

  mahony_orientation_update_checker u_checker (.*);

  always @(posedge clk) begin
    if (hold_req && hold_left == 0) hold_left <= HOLD_CYCLES;
    if (hold_left > 1) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
      if (hold_left == 1) hold_left <= -1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_gains(input logic [31:0] dt, input logic [31:0] kp,
                             input logic [31:0] ki);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SAMPLE_PERIOD;
    cfg_data <= dt;
    @(posedge clk);
    cfg_index <= CFG_PROP_GAIN;
    cfg_data <= kp;
    @(posedge clk);
    cfg_index <= CFG_INT_GAIN;
    cfg_data <= ki;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [15:0] ax, ay, az,
                             input logic signed [31:0] gx, gy, gz);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= ax; accel_y <= ay; accel_z <= az;
    gyro_x <= gx;  gyro_y <= gy;  gyro_z <= gz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_rate();
    return ($urandom_range(1)) ? $urandom : $urandom_range(32'h0200_0000) - 32'h0100_0000;
  endfunction

  task automatic send_random;
    logic signed [15:0] ax, ay, az;
    int pick;
    pick = int'($urandom_range(9));
    ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
    if (pick == 0) begin
      ax = '0; ay = '0; az = '0;
    end else if (pick < 4) begin
      ax = 16'($urandom_range(400) - 200);
      ay = 16'($urandom_range(400) - 200);
      az = 16'(16384 + $urandom_range(400) - 200);
    end
    send_sample(ax, ay, az, rand_rate(), rand_rate(), rand_rate());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: defaults, zero accel, field extremes
    send_sample(16'sd0, 16'sd0, 16'sd0, 32'sd1000, -32'sd1000, 32'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd16384, 32'sd0, 32'sd0, 32'sd0);
    send_sample(16'sd32767, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_sample(-16'sd32768, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_sample(16'sd0, -16'sd32768, 16'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_sample(16'sd0, 16'sd0, -16'sd32768, 32'sd0, 32'sd0, 32'sd0);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000);
    send_sample(16'sd1, 16'sd0, 16'sd0, 32'hFFFF_FFFF, 32'sd1, -32'sd1);
    send_sample(16'sd0, 16'sd0, 16'sd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd0);
    send_sample(16'sd100, -16'sd50, 16'sd16000, 32'sd6553600, -32'sd6553600, 32'sd655360);
    drain();
    // extremes: largest gains and step, drives the integral into saturation
    write_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++)
      send_sample(16'sd32767, 16'sd0, 16'sd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd12345);
    send_sample(-16'sd32768, 16'sd32767, 16'sd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd0);
    drain();
    write_gains(32'd0, 32'd0, 32'd0);
    send_sample(16'sd300, 16'sd200, 16'sd100, 32'h7FFF_FFFF, 32'sd0, 32'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 15 : ((mode == 1) ? 65 : 0);
      rx_idle_pct = (mode == 0) ? 65 : ((mode == 1) ? 15 : 0);
      for (int blk = 0; blk < 4; blk++) begin
        case (blk)
          0: write_gains($urandom_range(32'h0800_0000), $urandom, $urandom_range(32'h0400_0000));
          1: write_gains(SAMPLE_PERIOD_RST, PROP_GAIN_RST, INT_GAIN_RST);
          2: write_gains($urandom, $urandom, $urandom);
          default: write_gains(32'h0041_8937, 32'h0200_0000, 32'h0001_0000);
        endcase
        for (int i = 0; i < 50; i++) begin
          if (mode == 2 && blk == 1 && i == 10) hold_req = 1'b1;
          if (mode == 2 && blk == 3 && i == 25) drain();
          send_random();
        end
        in_valid <= 1'b0;
        drain();
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (500) @(posedge clk);
    leftover = (pending_count != 0);
    if (fail_count == 0 && !leftover) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
